FILE: hdl/lgci_pkg.sv
// shared types, constants and helpers for the case-insensitive line grep
`default_nettype none
package lgci_pkg;

  localparam int MAX_QUERY_DEF = 32;
  localparam int MAX_NOTES_DEF = 256;
  localparam int LINE_BITS_DEF = 16;

  localparam int QUERY_CHARS = 32;
  localparam int EVQ_DEPTH   = 4;
  localparam int RESQ_DEPTH  = 2;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_ADDR_W-1:0] CFG_QUERY_0  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_QUERY_1  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_QUERY_2  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_QUERY_3  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_QLEN     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_HITS = 3'd5;

  typedef logic [QUERY_CHARS-1:0][7:0] query_t;

  typedef struct packed {
    logic       new_search;
    logic       first_of_note;
    logic [7:0] note_index;
    logic       note_locked;
    logic [7:0] text_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]  hit_note;
    logic [15:0] hit_line;
  } out_t;

  // one classified byte handed from front to back
  typedef struct packed {
    logic       new_search;
    logic       first_of_note;
    logic       newline;
    logic       cand;
    logic [7:0] note;
  } evt_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5a]}) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/lgci_fifo.sv
// small first-in first-out queue of fixed-width entries
`default_nettype none
module lgci_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/lgci_front.sv
// front end: folds bytes, keeps the byte window and compares it with the query
`default_nettype none
module lgci_front #(
  parameter int MAX_QUERY = lgci_pkg::MAX_QUERY_DEF,
  parameter int MAX_NOTES = lgci_pkg::MAX_NOTES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_push,
  input  wire lgci_pkg::in_t   in_item,
  input  wire lgci_pkg::query_t query,
  input  wire logic [5:0]      qlen,
  input  wire logic            evq_full,
  output logic                 evq_push,
  output lgci_pkg::evt_t       evq_data
);

  localparam int CW = $clog2(MAX_QUERY + 1);

  logic [MAX_QUERY-1:0][7:0] win_r, win_nxt, win_sh;
  logic [CW-1:0]             chars_r, chars_nxt, chars_base, chars_sh;
  logic [MAX_QUERY-1:0]      pos_ok;
  logic                      nl, qlen_ok, note_ok;

  assign evq_push = in_push && !evq_full;
  assign nl       = (in_item.text_byte == lgci_pkg::NEWLINE_BYTE);
  assign qlen_ok  = (qlen != 6'd0) && (7'(qlen) <= 7'(MAX_QUERY));
  assign note_ok  = (32'(in_item.note_index) < 32'(MAX_NOTES));

  always_comb begin
    logic [5:0] idx;
    idx        = '0;
    chars_base = in_item.first_of_note ? '0 : chars_r;
    chars_sh   = (chars_base == CW'(MAX_QUERY)) ? chars_base : chars_base + CW'(1);
    chars_nxt  = nl ? '0 : chars_sh;
    win_sh[0]  = lgci_pkg::fold(in_item.text_byte);
    for (int j = 1; j < MAX_QUERY; j++) begin
      win_sh[j] = win_r[j-1];
    end
    win_nxt = nl ? win_r : win_sh;
    // window slot j holds the byte that must equal query char qlen-1-j
    for (int j = 0; j < MAX_QUERY; j++) begin
      idx       = qlen - 6'd1 - 6'(j);
      pos_ok[j] = (6'(j) >= qlen) || (win_sh[j] == query[idx[4:0]]);
    end
  end

  always_comb begin
    evq_data.new_search    = in_item.new_search;
    evq_data.first_of_note = in_item.first_of_note;
    evq_data.newline       = nl;
    evq_data.note          = in_item.note_index;
    evq_data.cand          = !nl && !in_item.note_locked && qlen_ok && note_ok &&
                             (7'(chars_sh) >= 7'(qlen)) && (&pos_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_r <= '0;
    end else if (evq_push) begin
      chars_r <= chars_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (evq_push) begin
      win_r <= win_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/lgci_back.sv
// back end: line numbers, per-line match flag and hit budget
`default_nettype none
module lgci_back #(
  parameter int LINE_BITS = lgci_pkg::LINE_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           evq_empty,
  input  wire lgci_pkg::evt_t evq_data,
  output logic                evq_pop,
  input  wire logic [9:0]     max_hits,
  input  wire logic           res_full,
  output logic                res_push,
  output lgci_pkg::out_t      res_data
);

  logic [LINE_BITS-1:0] line_r, line_nxt, line_base;
  logic                 matched_r, matched_nxt, matched_base;
  logic [9:0]           hits_r, hits_nxt, hits_base;
  logic                 hit;

  assign evq_pop = !evq_empty && !res_full;

  always_comb begin
    hits_base    = evq_data.new_search ? '0 : hits_r;
    line_base    = evq_data.first_of_note ? LINE_BITS'(1) : line_r;
    matched_base = evq_data.first_of_note ? 1'b0 : matched_r;
    hit          = 1'b0;
    line_nxt     = line_base;
    matched_nxt  = matched_base;
    hits_nxt     = hits_base;
    if (evq_data.newline) begin
      line_nxt    = (&line_base) ? line_base : line_base + LINE_BITS'(1);
      matched_nxt = 1'b0;
    end else begin
      hit         = evq_data.cand && !matched_base && (hits_base < max_hits);
      matched_nxt = matched_base || hit;
      hits_nxt    = hits_base + 10'(hit);
    end
    res_data.hit_note = evq_data.note;
    res_data.hit_line = 16'(line_base);
  end

  assign res_push = evq_pop && hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r    <= LINE_BITS'(1);
      matched_r <= 1'b0;
      hits_r    <= '0;
    end else if (evq_pop) begin
      line_r    <= line_nxt;
      matched_r <= matched_nxt;
      hits_r    <= hits_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/line_grep_case_insensitive.sv
// Case-insensitive line grep over a stream of note bytes. One byte is taken per
// clock while the byte queue has room. The front end compares the whole window
// of recent bytes with the query in the cycle a byte arrives and writes one
// request per byte into a 4-entry queue; the back end drains one request per
// cycle unless the result queue is full, keeping line numbers and the hit
// budget, and writes hits into a 2-entry result queue. Input full rises only
// when the result queue is full and the byte queue has filled behind it.
// Register writes take effect at the next edge.
`default_nettype none
module line_grep_case_insensitive #(
  parameter int MAX_QUERY = lgci_pkg::MAX_QUERY_DEF,
  parameter int MAX_NOTES = lgci_pkg::MAX_NOTES_DEF,
  parameter int LINE_BITS = lgci_pkg::LINE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  input  wire lgci_pkg::in_t                   in_item,
  output logic                                 in_full,
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output lgci_pkg::out_t                       out_item,
  input  wire logic                            cfg_we,
  input  wire logic [lgci_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [lgci_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int EVT_W = $bits(lgci_pkg::evt_t);
  localparam int RES_W = $bits(lgci_pkg::out_t);

  lgci_pkg::query_t query_r;
  logic [5:0]       qlen_r;
  logic [9:0]       max_hits_r;

  lgci_pkg::evt_t   evq_wdata, evq_rdata;
  logic             evq_push, evq_full, evq_pop, evq_empty;
  lgci_pkg::out_t   res_wdata;
  logic             res_push, res_full;

  // query bytes are stored already folded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_r    <= '0;
      qlen_r     <= '0;
      max_hits_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        lgci_pkg::CFG_QUERY_0, lgci_pkg::CFG_QUERY_1,
        lgci_pkg::CFG_QUERY_2, lgci_pkg::CFG_QUERY_3: begin
          for (int b = 0; b < 8; b++) begin
            query_r[{cfg_addr[1:0], 3'(b)}] <= lgci_pkg::fold(cfg_data[8*b +: 8]);
          end
        end
        lgci_pkg::CFG_QLEN: begin
          qlen_r <= cfg_data[5:0];
        end
        lgci_pkg::CFG_MAX_HITS: begin
          max_hits_r <= cfg_data[9:0];
        end
        default: begin
        end
      endcase
    end
  end

  lgci_front #(
    .MAX_QUERY (MAX_QUERY),
    .MAX_NOTES (MAX_NOTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .query    (query_r),
    .qlen     (qlen_r),
    .evq_full (evq_full),
    .evq_push (evq_push),
    .evq_data (evq_wdata)
  );

  lgci_fifo #(
    .WIDTH (EVT_W),
    .DEPTH (lgci_pkg::EVQ_DEPTH)
  ) u_evq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (evq_push),
    .wdata (evq_wdata),
    .full  (evq_full),
    .pop   (evq_pop),
    .rdata (evq_rdata),
    .empty (evq_empty)
  );

  lgci_back #(
    .LINE_BITS (LINE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .evq_empty (evq_empty),
    .evq_data  (evq_rdata),
    .evq_pop   (evq_pop),
    .max_hits  (max_hits_r),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_wdata)
  );

  lgci_fifo #(
    .WIDTH (RES_W),
    .DEPTH (lgci_pkg::RESQ_DEPTH)
  ) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_item),
    .empty (out_empty)
  );

  assign in_full = evq_full;

`ifndef ASSERT_OFF
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("hit written into a full result queue");

  a_evq_drain: assert property (@(posedge clk) disable iff (!rst_n)
    evq_pop |-> !evq_empty && !res_full)
    else $error("request taken from an empty byte queue or with no room for a hit");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not cleared by reset");

  a_hit_needs_cand: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> evq_rdata.cand && !evq_rdata.newline && max_hits_r != 10'd0)
    else $error("hit without a matching request or with no hit budget");
`endif

endmodule
`default_nettype wire
